### src/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset-qualified
`define CKSB_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cksb assertion failed");

// next-cycle implication, reset-qualified
`define CKSB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cksb assertion failed");

`endif

### src/cksb_pkg.sv
// types and constants of the colour-keyed sprite blitter
`default_nettype none

package cksb_pkg;

	localparam int PIX_W      = 32;
	localparam int ADDR_W     = 16;
	localparam int STORE_DEPTH = 65536;
	localparam int POS_W      = 11;
	localparam int SIZE_W     = 12;
	localparam int ORG_W      = 13;
	localparam int REG_IDX_W  = 3;

	localparam logic [SIZE_W-1:0] SIZE_MAX = 12'd2048;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y   = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WIDTH      = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_ALIGN      = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_KEY_COLOR  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_HIT_A      = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_HIT_B      = 3'd7;

	// alignment codes
	localparam logic [1:0] ALIGN_LEFT = 2'd0;
	localparam logic [1:0] ALIGN_HALF = 2'd1;
	localparam logic [1:0] ALIGN_FULL = 2'd2;

	// command codes
	localparam logic CMD_BLIT = 1'b0;
	localparam logic CMD_READ = 1'b1;

	// register reset values
	localparam logic [PIX_W-1:0] KEY_RESET   = 32'h001f_0ff8;
	localparam logic [PIX_W-1:0] HIT_A_RESET = 32'h0063_0000;
	localparam logic [PIX_W-1:0] HIT_B_RESET = 32'h00ed_5c22;

	typedef struct packed {
		logic signed [ORG_W-1:0] origin_x;
		logic signed [ORG_W-1:0] origin_y;
		logic [SIZE_W-1:0]       width;
		logic [SIZE_W-1:0]       height;
		logic [1:0]              align;
		logic [PIX_W-1:0]        key_color;
	} place_cfg_t;

	// one request leaving the placement stage
	typedef struct packed {
		logic              cmd;
		logic              wr;
		logic              done;
		logic [PIX_W-1:0]  pix;
		logic [ADDR_W-1:0] rd_addr;
		logic [POS_W-1:0]  col;
		logic [POS_W-1:0]  row;
	} blit_req_t;

endpackage

`default_nettype wire

### src/color_keyed_sprite_blitter.sv
// top level of the colour-keyed sprite blitter
// usage:
//   s_axis carries one command per transaction: tuser selects a sprite pixel blit (0)
//   or a frame word read (1); tdata holds the pixel and the read address.
//   sprite pixels arrive bottom row first, each row left to right; the block keeps
//   its own column and row counters and wraps them at the sprite size.
//   m_axis returns exactly one result per command; tlast marks the sprite's last
//   pixel, and on that result the collision bit reports the whole sprite.
//   cfg is a write-only register channel (always ready); write it while idle.
// timing:
//   one command per cycle sustained while m_axis_tready is high; the frame store has
//   one read and one write port, read at stage 1 and written back at stage 2, and a
//   result passes through stage 1, stage 2 and the output register. same-address
//   back-to-back pixels are bypassed from the write stage, so there is no interlock.
// reset:
//   counters, collision flag and registers return to their defaults; the frame
//   store itself is not cleared, so words must be written before they are read.
// stall:
//   a held result stays on m_axis; commands are taken only while the pipeline can move,
//   and s_axis_tready drops in the same cycle once stages 1 and 2 are full behind a held result.
`default_nettype none

module color_keyed_sprite_blitter import cksb_pkg::*; #(
	parameter int FRAME_W = 256,
	parameter int FRAME_H = 256
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// command stream
	input  wire logic                 s_axis_tvalid,
	output      logic                 s_axis_tready,
	input  wire logic [47:0]          s_axis_tdata,   // src_pixel[31:0], read_addr[47:32]
	input  wire logic                 s_axis_tuser,   // cmd
	// result stream
	output      logic                 m_axis_tvalid,
	input  wire logic                 m_axis_tready,
	output      logic [39:0]          m_axis_tdata,   // wrote[0], collided[1], read_data[33:2], zero pad
	output      logic                 m_axis_tlast,   // sprite_done
	// register writes
	input  wire logic                 cfg_valid,
	output      logic                 cfg_ready,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [31:0]          cfg_data
);

	place_cfg_t cfg_q;
	logic [PIX_W-1:0] hit_a_q, hit_b_q;
	blit_req_t req;
	logic accept, wrote, collided;
	logic [PIX_W-1:0] read_data;

	// register file: always ready, every write is accepted and registered
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x  <= '0;
			cfg_q.origin_y  <= '0;
			cfg_q.width     <= 12'd1;
			cfg_q.height    <= 12'd1;
			cfg_q.align     <= ALIGN_LEFT;
			cfg_q.key_color <= KEY_RESET;
			hit_a_q         <= HIT_A_RESET;
			hit_b_q         <= HIT_B_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X:  cfg_q.origin_x  <= cfg_data[ORG_W-1:0];
				REG_ORIGIN_Y:  cfg_q.origin_y  <= cfg_data[ORG_W-1:0];
				REG_WIDTH:     cfg_q.width     <= cfg_data[SIZE_W-1:0];
				REG_HEIGHT:    cfg_q.height    <= cfg_data[SIZE_W-1:0];
				REG_ALIGN:     cfg_q.align     <= cfg_data[1:0];
				REG_KEY_COLOR: cfg_q.key_color <= cfg_data;
				REG_HIT_A:     hit_a_q         <= cfg_data;
				REG_HIT_B:     hit_b_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept = s_axis_tvalid && s_axis_tready;

	// stage 0: counters, alignment, clipping and colour key
	cksb_place #(
		.FRAME_W (FRAME_W),
		.FRAME_H (FRAME_H)
	) u_place (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.cmd     (s_axis_tuser),
		.pix     (s_axis_tdata[31:0]),
		.rd_addr (s_axis_tdata[47:32]),
		.cfg     (cfg_q),
		.req     (req)
	);

	// stages 1 and 2 plus the output register
	cksb_rmw #(
		.FRAME_W (FRAME_W)
	) u_rmw (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.req       (req),
		.hit_a     (hit_a_q),
		.hit_b     (hit_b_q),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_wrote (wrote),
		.out_done  (m_axis_tlast),
		.out_coll  (collided),
		.out_rdata (read_data)
	);

	assign m_axis_tdata = {6'b000000, read_data, collided, wrote};

endmodule

`default_nettype wire

### src/cksb_ram.sv
// generic single-port-write, registered-read memory
`default_nettype none

module cksb_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

endmodule

`default_nettype wire

### src/cksb_place.sv
// sprite walk counters and screen placement with clipping
`default_nettype none

module cksb_place import cksb_pkg::*; #(
	parameter int FRAME_W = 256,
	parameter int FRAME_H = 256
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              accept,
	input  wire logic              cmd,
	input  wire logic [PIX_W-1:0]  pix,
	input  wire logic [ADDR_W-1:0] rd_addr,
	input  wire place_cfg_t        cfg,
	output      blit_req_t         req
);

	logic [POS_W-1:0] src_col_q, src_row_q;
	logic [SIZE_W-1:0] w, h, shift;
	logic [POS_W-1:0] col_cur, row_cur, col_next, row_next;
	logic signed [14:0] x0, col, row;
	logic last_col, last_row, in_frame;

	always_comb begin
		w = cfg.width;
		if (cfg.width == '0) begin
			w = 12'd1;
		end else if (cfg.width > SIZE_MAX) begin
			w = SIZE_MAX;
		end
		h = cfg.height;
		if (cfg.height == '0) begin
			h = 12'd1;
		end else if (cfg.height > SIZE_MAX) begin
			h = SIZE_MAX;
		end

		// counters beyond a shrunk size wrap
		col_cur = ({1'b0, src_col_q} >= w) ? '0 : src_col_q;
		row_cur = ({1'b0, src_row_q} >= h) ? '0 : src_row_q;

		case (cfg.align)
			ALIGN_HALF: shift = w >> 1;
			ALIGN_FULL: shift = w;
			default:    shift = '0;
		endcase

		x0  = 15'(cfg.origin_x) - $signed({3'b000, shift});
		col = x0 + $signed({4'b0000, col_cur});
		row = 15'(cfg.origin_y) + $signed({3'b000, h}) - 15'sd1
			- $signed({4'b0000, row_cur});

		in_frame = !col[14] && (col[13:0] < 14'(FRAME_W))
			&& !row[14] && (row[13:0] < 14'(FRAME_H));

		last_col = ({1'b0, col_cur} + 12'd1) >= w;
		last_row = ({1'b0, row_cur} + 12'd1) >= h;

		col_next = last_col ? '0 : col_cur + 11'd1;
		row_next = row_cur;
		if (last_col) begin
			row_next = last_row ? '0 : row_cur + 11'd1;
		end

		req.cmd     = cmd;
		req.wr      = (cmd == CMD_BLIT) && in_frame && (pix != cfg.key_color);
		req.done    = (cmd == CMD_BLIT) && last_col && last_row;
		req.pix     = pix;
		req.rd_addr = rd_addr;
		req.col     = col[POS_W-1:0];
		req.row     = row[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
		end else if (accept && (cmd == CMD_BLIT)) begin
			src_col_q <= col_next;
			src_row_q <= row_next;
		end
	end

endmodule

`default_nettype wire

### src/cksb_rmw.sv
// frame store read-modify-write pipeline with forwarding and collision tracking
`default_nettype none

module cksb_rmw import cksb_pkg::*; #(
	parameter int FRAME_W = 256
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output      logic             in_ready,
	input  wire blit_req_t        req,
	input  wire logic [PIX_W-1:0] hit_a,
	input  wire logic [PIX_W-1:0] hit_b,
	output      logic             out_valid,
	input  wire logic             out_ready,
	output      logic             out_wrote,
	output      logic             out_done,
	output      logic             out_coll,
	output      logic [PIX_W-1:0] out_rdata
);

	blit_req_t req_s1;
	logic vld_s1, vld_s2;
	logic cmd_s2, wr_s2, done_s2, fwd_s2;
	logic [PIX_W-1:0] pix_s2, fwd_data_s2;
	logic [ADDR_W-1:0] addr_s2;
	logic out_valid_q, out_wrote_q, out_done_q, out_coll_q, coll_q;
	logic [PIX_W-1:0] out_rdata_q;

	logic s2_move, s1_move, s2_write, hit;
	logic [31:0] lin_addr;
	logic [ADDR_W-1:0] addr_s1;
	logic [PIX_W-1:0] rdata, old;

	assign s2_move  = !out_valid_q || out_ready;
	assign s1_move  = !vld_s2 || s2_move;
	assign in_ready = !vld_s1 || s1_move;
	assign s2_write = vld_s2 && s2_move && wr_s2;

	assign lin_addr = 32'(req_s1.row) * 32'(FRAME_W) + 32'(req_s1.col);
	assign addr_s1  = (req_s1.cmd == CMD_READ) ? req_s1.rd_addr : lin_addr[ADDR_W-1:0];

	cksb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_frame (
		.clk   (clk),
		.we    (s2_write),
		.waddr (addr_s2),
		.wdata (pix_s2),
		.re    (vld_s1 && s1_move),
		.raddr (addr_s1),
		.rdata (rdata)
	);

	// a write leaving s2 in the same cycle as the read is bypassed
	assign old = fwd_s2 ? fwd_data_s2 : rdata;
	assign hit = wr_s2 && ((old == hit_a) || (old == hit_b));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			vld_s2      <= 1'b0;
			out_valid_q <= 1'b0;
			coll_q      <= 1'b0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (s1_move) begin
				vld_s2 <= vld_s1;
			end
			if (s2_move) begin
				out_valid_q <= vld_s2;
			end
			if (vld_s2 && s2_move && (cmd_s2 == CMD_BLIT)) begin
				coll_q <= done_s2 ? 1'b0 : (coll_q || hit);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= req;
		end
		if (vld_s1 && s1_move) begin
			cmd_s2      <= req_s1.cmd;
			wr_s2       <= req_s1.wr;
			done_s2     <= req_s1.done;
			pix_s2      <= req_s1.pix;
			addr_s2     <= addr_s1;
			fwd_s2      <= s2_write && (addr_s2 == addr_s1);
			fwd_data_s2 <= pix_s2;
		end
		if (vld_s2 && s2_move) begin
			out_wrote_q <= wr_s2;
			out_done_q  <= done_s2;
			out_coll_q  <= done_s2 && (coll_q || hit);
			out_rdata_q <= (cmd_s2 == CMD_READ) ? old : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_wrote = out_wrote_q;
	assign out_done  = out_done_q;
	assign out_coll  = out_coll_q;
	assign out_rdata = out_rdata_q;

endmodule

`default_nettype wire

### src/cksb_checker.sv
// port-level checker for the sprite blitter, bound to the top level
`default_nettype none
`include "assert_macros.svh"

module cksb_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic        m_axis_tlast
);

	// a held result keeps its contents
	`CKSB_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

	// collision is only reported on the sprite's last pixel
	`CKSB_ASSERT_NOW(a_coll_on_last, clk, arst_n, m_axis_tvalid && m_axis_tdata[1], m_axis_tlast)

	// read data only ever comes with a read result
	`CKSB_ASSERT_NOW(a_read_clean, clk, arst_n, m_axis_tvalid && (m_axis_tdata[33:2] != 32'd0), !m_axis_tdata[0] && !m_axis_tlast)

	// with nothing waiting at the output the pipeline takes a command
	`CKSB_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready)

endmodule

bind color_keyed_sprite_blitter cksb_checker u_cksb_checker (.*);

`default_nettype wire
